@@ rtl/core/pkr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkr_pkg
// Shared types and register codes of the multi-head block slot packer.
// ----------------------------------------------------------------------------
package pkr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DIM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 3'd5;

    localparam logic [19:0] VEC_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [15:0] row_index;
        logic [15:0] column_index;
        logic [15:0] replica;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic [19:0] vector_index;
        logic [15:0] slot_index;
    } t_out;

    // configuration and the values derived from it
    typedef struct packed {
        logic        ready;
        logic        bad;
        logic [15:0] row_count;
        logic [15:0] column_count;
        logic [8:0]  d;
        logic [12:0] hw;
        logic [21:0] mbw;
        logic [16:0] s;
        logic [15:0] chunk;
        logic [16:0] chunks;
        logic [9:0]  groups;
        logic [15:0] nbr;
        logic [20:0] per_mb;
    } t_setup;

endpackage

@@ rtl/core/pkr_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkr_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pkr_div_pipe #(
    parameter int NW = 16,
    parameter int DW = 9,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_side
);

    logic [NW-1:0] r_v;
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_num  [NW];
    logic [PW-1:0] r_side [NW];

    logic [NW-1:0] w_src_v;
    logic [DW-1:0] w_src_rem  [NW];
    logic [NW-1:0] w_src_num  [NW];
    logic [PW-1:0] w_src_side [NW];
    logic [DW:0]   w_trial    [NW];
    logic [NW-1:0] w_q;
    logic [DW-1:0] n_rem      [NW];
    logic [NW-1:0] n_num      [NW];

    always_comb begin
        w_src_v[0]    = i_valid;
        w_src_rem[0]  = '0;
        w_src_num[0]  = i_num;
        w_src_side[0] = i_side;
        for (int k = 1; k < NW; k++) begin
            w_src_v[k]    = r_v[k-1];
            w_src_rem[k]  = r_rem[k-1];
            w_src_num[k]  = r_num[k-1];
            w_src_side[k] = r_side[k-1];
        end
        for (int k = 0; k < NW; k++) begin
            w_trial[k] = {w_src_rem[k], w_src_num[k][NW-1]};
            w_q[k]     = (w_trial[k] >= {1'b0, i_den});
            n_rem[k]   = w_q[k] ? DW'(w_trial[k] - {1'b0, i_den}) : w_trial[k][DW-1:0];
            n_num[k]   = {w_src_num[k][NW-2:0], w_q[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= w_src_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_num[k]  <= n_num[k];
                r_side[k] <= w_src_side[k];
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

@@ rtl/core/pkr_setup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkr_setup
// Configuration registers and a sequencer that derives the packing setup
// with one shared serial divider.
// ----------------------------------------------------------------------------
module pkr_setup import pkr_pkg::*; #(
    parameter int MAX_SLOTS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_setup                o_setup
);

    typedef enum logic [6:0] {
        ST_PRE   = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_STORE = 7'b0010000,
        ST_MUL   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    localparam logic [2:0] JOB_S      = 3'd0;
    localparam logic [2:0] JOB_GROUPS = 3'd1;
    localparam logic [2:0] JOB_CHUNKS = 3'd2;
    localparam logic [2:0] JOB_NBR    = 3'd3;
    localparam logic [2:0] JOB_NBC    = 3'd4;

    logic [15:0] r_row_count, r_column_count;
    logic [8:0]  r_d, r_nh;
    logic [12:0] r_hw;
    logic [16:0] r_ns;

    t_state      r_state;
    logic [2:0]  r_job;
    logic        r_mul2;
    logic [17:0] r_dd;
    logic [21:0] r_mbw;
    logic [9:0]  r_pad;
    logic        r_bad, r_big;
    logic [27:0] r_chunk;
    logic [16:0] r_s, r_chunks;
    logic [9:0]  r_groups;
    logic [15:0] r_nbr;
    logic [13:0] r_nbc;
    logic [29:0] r_m1;
    logic [20:0] r_per_mb;

    logic [16:0] r_dnum;
    logic [27:0] r_drem, r_dden;
    logic [4:0]  r_dcnt;

    logic [27:0] w_padd;
    logic [28:0] w_trial;
    logic        w_dq;
    logic [9:0]  w_pad_div;
    logic [39:0] w_m2;

    function automatic logic [9:0] pow2_ceil(input logic [8:0] x);
        logic [9:0] p;
        p = 10'd512;
        for (int k = 9; k >= 0; k--) begin
            if ((10'd1 << k) >= {1'b0, x}) begin
                p = 10'd1 << k;
            end
        end
        return p;
    endfunction

    assign w_padd    = 28'(r_pad) * 28'(r_dd);
    assign w_trial   = {r_drem, r_dnum[16]};
    assign w_dq      = (w_trial >= {1'b0, r_dden});
    assign w_pad_div = (!r_big && r_s == 17'd1) ? {1'b0, r_nh} : r_pad;
    assign w_m2      = 40'(r_m1) * 40'(r_groups);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= 16'd1;
            r_column_count <= 16'd1;
            r_d            <= 9'd1;
            r_nh           <= 9'd1;
            r_hw           <= 13'd1;
            r_ns           <= 17'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_COUNT:    r_row_count    <= i_cfg_data[15:0];
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_data[15:0];
                CFG_BLOCK_DIM:    r_d            <= i_cfg_data[8:0];
                CFG_HEAD_COUNT:   r_nh           <= i_cfg_data[8:0];
                CFG_HEAD_WIDTH:   r_hw           <= i_cfg_data[12:0];
                CFG_SLOT_COUNT:   r_ns           <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PRE;
        end else if (i_cfg_we) begin
            r_state <= ST_PRE;
        end else begin
            unique case (r_state)
                ST_PRE:   r_state <= ST_PAD;
                ST_PAD:   r_state <= ST_LOAD;
                ST_LOAD:  r_state <= ST_DIV;
                ST_DIV:   if (r_dcnt == 5'd16) r_state <= ST_STORE;
                ST_STORE: r_state <= (r_job == JOB_NBC) ? ST_MUL : ST_LOAD;
                ST_MUL:   if (r_mul2) r_state <= ST_DONE;
                ST_DONE:  r_state <= ST_DONE;
                default:  r_state <= ST_PRE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_PRE: begin
                r_dd   <= 18'(r_d) * 18'(r_d);
                r_mbw  <= 22'(r_hw) * 22'(r_nh);
                r_pad  <= pow2_ceil(r_nh);
                r_bad  <= (r_d == '0) || (r_nh == '0) || (r_hw == '0) || (r_ns == '0)
                          || (32'(r_ns) > 32'(MAX_SLOTS));
                r_job  <= JOB_S;
                r_mul2 <= 1'b0;
            end
            ST_PAD: begin
                r_big   <= (28'(r_ns) >= w_padd);
                r_chunk <= (28'(r_ns) >= w_padd) ? w_padd : 28'(r_ns);
            end
            ST_LOAD: begin
                r_drem <= '0;
                r_dcnt <= '0;
                case (r_job)
                    JOB_S:      begin r_dnum <= r_ns; r_dden <= 28'(r_dd); end
                    JOB_GROUPS: begin r_dnum <= 17'(w_pad_div); r_dden <= 28'(r_s); end
                    JOB_CHUNKS: begin r_dnum <= r_ns; r_dden <= r_chunk; end
                    JOB_NBR: begin
                        r_dnum <= 17'(r_row_count) + 17'(r_d) - 17'd1;
                        r_dden <= 28'(r_d);
                    end
                    default: begin
                        r_dnum <= 17'(r_hw) + 17'(r_d) - 17'd1;
                        r_dden <= 28'(r_d);
                    end
                endcase
            end
            ST_DIV: begin
                r_drem <= w_dq ? 28'(w_trial - {1'b0, r_dden}) : w_trial[27:0];
                r_dnum <= {r_dnum[15:0], w_dq};
                r_dcnt <= r_dcnt + 5'd1;
            end
            ST_STORE: begin
                r_job <= r_job + 3'd1;
                case (r_job)
                    JOB_S: begin
                        r_s <= r_big ? 17'(r_pad) : r_dnum;
                        if (!r_big && r_dnum == '0) r_bad <= 1'b1;
                    end
                    JOB_GROUPS: r_groups <= r_big ? 10'd1 : r_dnum[9:0];
                    JOB_CHUNKS: r_chunks <= r_dnum;
                    JOB_NBR:    r_nbr    <= r_dnum[15:0];
                    default:    r_nbc    <= r_dnum[13:0];
                endcase
            end
            ST_MUL: begin
                r_mul2 <= 1'b1;
                if (!r_mul2) begin
                    r_m1 <= 30'(r_nbr) * 30'(r_nbc);
                end else begin
                    // saturate: anything past the vector range overflows anyway
                    r_per_mb <= (|w_m2[39:20]) ? 21'h100000 : w_m2[20:0];
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        o_setup.ready        = (r_state == ST_DONE);
        o_setup.bad          = r_bad;
        o_setup.row_count    = r_row_count;
        o_setup.column_count = r_column_count;
        o_setup.d            = r_d;
        o_setup.hw           = r_hw;
        o_setup.mbw          = r_mbw;
        o_setup.s            = r_s;
        o_setup.chunk        = r_chunk[15:0];
        o_setup.chunks       = r_chunks;
        o_setup.groups       = r_groups;
        o_setup.nbr          = r_nbr;
        o_setup.per_mb       = r_per_mb;
    end

endmodule

@@ rtl/core/multihead_block_slot_packer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multihead_block_slot_packer_top
// Maps a matrix element (row, column, replica) to a packed vector index and
// slot index through a chain of pipelined dividers and multiply stages.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   in      | input     | i_valid / o_stall   | i_item (t_in)
//   out     | output    | o_valid / i_stall   | o_item (t_out)
//   cfg     | input     | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One item per cycle while the output does not stall and setup is not running; the
// pipeline is an input register, three divider chains of 16, 16 and 13 stages, three multiply stages, output.
// After reset and after each register write the setup sequencer runs
// on one serial divider; o_stall is high meanwhile.
// A stall on the output freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module multihead_block_slot_packer_top import pkr_pkg::*; #(
    parameter int MAX_SLOTS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_setup w_cfg;
    logic   w_en;

    pkr_setup #(.MAX_SLOTS(MAX_SLOTS)) u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_setup    (w_cfg)
    );

    logic r_out_v;
    t_out r_out_item;

    assign w_en    = !r_out_v || !i_stall;
    assign o_stall = !w_cfg.ready || !w_en;
    assign o_valid = r_out_v;
    assign o_item  = r_out_item;

    // input register with range checks
    logic        r_a_v, r_a_drop;
    logic [15:0] r_a_r, r_a_gc, r_a_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid && w_cfg.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_r    <= i_item.row_index;
            r_a_gc   <= i_item.column_index;
            r_a_rep  <= i_item.replica;
            r_a_drop <= w_cfg.bad || (i_item.row_index >= w_cfg.row_count)
                        || (i_item.column_index >= w_cfg.column_count)
                        || (17'(i_item.replica) >= w_cfg.chunks);
        end
    end

    // megablock and block row
    logic        w1_v, w1_drop;
    logic [15:0] w1_mb, w1_bi, w1_rep;
    logic [21:0] w1_within;
    logic [8:0]  w1_ri;

    pkr_div_pipe #(.NW(16), .DW(22), .PW(1)) u_div_mb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r_a_v), .i_num(r_a_gc), .i_den(w_cfg.mbw), .i_side(r_a_drop),
        .o_valid(w1_v), .o_quo(w1_mb), .o_rem(w1_within), .o_side(w1_drop)
    );

    pkr_div_pipe #(.NW(16), .DW(9), .PW(16)) u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r_a_v), .i_num(r_a_r), .i_den(w_cfg.d), .i_side(r_a_rep),
        .o_valid(), .o_quo(w1_bi), .o_rem(w1_ri), .o_side(w1_rep)
    );

    // head and column inside the head
    localparam int SIDE2_W = 1 + 16 + 16 + 9 + 16;
    logic               w2_v;
    logic [15:0]        w2_h;
    logic [12:0]        w2_c;
    logic [SIDE2_W-1:0] w2_side;

    pkr_div_pipe #(.NW(16), .DW(13), .PW(SIDE2_W)) u_div_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w1_v), .i_num(w1_within[15:0]), .i_den(w_cfg.hw),
        .i_side({w1_drop, w1_mb, w1_bi, w1_ri, w1_rep}),
        .o_valid(w2_v), .o_quo(w2_h), .o_rem(w2_c), .o_side(w2_side)
    );

    // group, head in group, block column, column inside block
    localparam int SIDE3_W = 1 + 16 + 16 + 9;
    logic               w3_v, w3_drop;
    logic [12:0]        w3_g, w3_bj;
    logic [16:0]        w3_hl;
    logic [8:0]         w3_cm, w3_ri;
    logic [15:0]        w3_mb, w3_bi, w3_rep;

    pkr_div_pipe #(.NW(13), .DW(17), .PW(SIDE3_W)) u_div_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w2_v), .i_num(w2_h[12:0]), .i_den(w_cfg.s),
        .i_side(w2_side[SIDE2_W-1:16]),
        .o_valid(w3_v), .o_quo(w3_g), .o_rem(w3_hl),
        .o_side({w3_drop, w3_mb, w3_bi, w3_ri})
    );

    pkr_div_pipe #(.NW(13), .DW(9), .PW(16)) u_div_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w2_v), .i_num(w2_c), .i_den(w_cfg.d), .i_side(w2_side[15:0]),
        .o_valid(), .o_quo(w3_bj), .o_rem(w3_cm), .o_side(w3_rep)
    );

    // multiply stages
    logic        r_m1_v, r_m1_ok;
    logic [36:0] r_m1_pmb;
    logic [28:0] r_m1_t1;
    logic [15:0] r_m1_bi, r_m1_repc;
    logic [17:0] r_m1_pos;
    logic [12:0] r_m1_g;
    logic [15:0] r_m1_hl;

    logic        r_m2_v, r_m2_ok;
    logic [29:0] r_m2_u;
    logic [15:0] r_m2_sm, r_m2_repc, r_m2_hl;
    logic [20:0] r_m2_pmb;
    logic [12:0] r_m2_g;

    logic        r_m3_v, r_m3_ok;
    logic [39:0] r_m3_v40;
    logic [15:0] r_m3_slot;
    logic [20:0] r_m3_pmb;
    logic [12:0] r_m3_g;

    logic [40:0] w_vec;
    logic        w_place;
    logic [31:0] w_repc;
    logic [31:0] w_sm;

    assign w_repc  = 32'(w3_rep) * 32'(w_cfg.chunk);
    assign w_sm    = 32'(r_m1_pos[15:0]) * 32'(w_cfg.s[15:0]);
    assign w_vec   = 41'(r_m3_pmb) + 41'(r_m3_v40) + 41'(r_m3_g);
    assign w_place = r_m3_ok && (w_vec <= 41'(VEC_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_m3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_m1_v  <= w3_v;
            r_m2_v  <= r_m1_v;
            r_m3_v  <= r_m2_v;
            r_out_v <= r_m3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_ok   <= !w3_drop && (w3_g < 13'(w_cfg.groups));
            r_m1_pmb  <= 37'(w3_mb) * 37'(w_cfg.per_mb);
            r_m1_t1   <= 29'(w_cfg.nbr) * 29'(w3_bj);
            r_m1_bi   <= w3_bi;
            r_m1_pos  <= 18'(w3_ri) + 18'(w_cfg.d) * 18'(w3_cm);
            r_m1_repc <= w_repc[15:0];
            r_m1_g    <= w3_g;
            r_m1_hl   <= w3_hl[15:0];

            r_m2_ok   <= r_m1_ok;
            r_m2_u    <= 30'(r_m1_t1) + 30'(r_m1_bi);
            r_m2_sm   <= w_sm[15:0];
            r_m2_repc <= r_m1_repc;
            r_m2_hl   <= r_m1_hl;
            r_m2_pmb  <= (|r_m1_pmb[36:20]) ? 21'h100000 : r_m1_pmb[20:0];
            r_m2_g    <= r_m1_g;

            r_m3_ok   <= r_m2_ok;
            r_m3_v40  <= 40'(r_m2_u) * 40'(w_cfg.groups);
            r_m3_slot <= r_m2_repc + r_m2_sm + r_m2_hl;
            r_m3_pmb  <= r_m2_pmb;
            r_m3_g    <= r_m2_g;

            r_out_item.valid_res    <= w_place;
            r_out_item.vector_index <= w_place ? w_vec[19:0] : '0;
            r_out_item.slot_index   <= w_place ? r_m3_slot : '0;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> w_cfg.ready)
        else $error("item accepted while setup runs");

    a_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("input not stalled after register write");

    a_dropped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.valid_res) |-> (o_item.vector_index == '0 && o_item.slot_index == '0))
        else $error("dropped item carries a nonzero address");
`endif

endmodule

@@ verif/tb_multihead_block_slot_packer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multihead_block_slot_packer_top
// Streams matrix elements through the slot packer under a series of register settings and checks
// each vector/slot address against a local address model or a table of expected addresses.
// ----------------------------------------------------------------------------
module tb_multihead_block_slot_packer_top;
    import pkr_pkg::*;

    localparam int LATENCY     = 50;
    localparam int MAX_SLOT_NB = 65536;
    localparam int N_PHASES    = 14;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in                   i_item;
    logic                  o_valid;
    logic                  i_stall;
    t_out                  o_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // current register contents as the address model sees them
    logic [15:0] m_rows;
    logic [15:0] m_cols;
    logic [8:0]  m_dim;
    logic [8:0]  m_heads;
    logic [12:0] m_hwidth;
    logic [16:0] m_slots;

    t_out     addr_queue[$];
    int       n_errors;
    t_dir_row dir_tab[16];

    multihead_block_slot_packer_top #(.MAX_SLOTS(MAX_SLOT_NB)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_out pack_addr(t_in x);
        longint unsigned r, gc, rep, d, nh, hw, ns, dd, pad, s, chunk, groups;
        longint unsigned chunks, mbw, mb, offs, h, c, g, hl, nbr, nbc, vec, slot;
        t_out res;
        res = '0;
        r = x.row_index;
        gc = x.column_index;
        rep = x.replica;
        d = m_dim;
        nh = m_heads;
        hw = m_hwidth;
        ns = m_slots;
        if (d == 0 || nh == 0 || hw == 0 || ns == 0 || ns > MAX_SLOT_NB) return res;
        if (r >= m_rows || gc >= m_cols) return res;
        dd = d * d;
        pad = 1;
        while (pad < nh) pad = pad << 1;
        if (ns >= pad * dd) begin
            s = pad;
            chunk = pad * dd;
            groups = 1;
        end else begin
            s = ns / dd;
            if (s == 0) return res;
            chunk = ns;
            if (s == 1) pad = nh;
            groups = pad / s;
        end
        chunks = ns / chunk;
        if (rep >= chunks) return res;
        mbw = hw * nh;
        mb = gc / mbw;
        offs = gc % mbw;
        h = offs / hw;
        c = offs % hw;
        g = h / s;
        hl = h % s;
        if (g >= groups) return res;
        nbr = (m_rows + d - 1) / d;
        nbc = (hw + d - 1) / d;
        vec = mb * nbr * nbc * groups + ((r / d) + nbr * (c / d)) * groups + g;
        if (vec > VEC_MAX) return res;
        slot = rep * chunk + ((r % d) + d * (c % d)) * s + hl;
        res.valid_res = 1'b1;
        res.vector_index = vec[19:0];
        res.slot_index = slot[15:0];
        return res;
    endfunction

    // receiver: stall pattern switches mode every so often
    int stall_mode;
    int stall_left;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (addr_queue.size() == 0) begin
                n_errors <= n_errors + 1;
                if (n_errors < 10) $display("unexpected item %h", o_item);
            end else begin
                want = addr_queue.pop_front();
                if (o_item.valid_res !== want.valid_res
                        || o_item.vector_index !== want.vector_index
                        || o_item.slot_index !== want.slot_index) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display("mismatch: exp %0d %0d %0d, got %0d %0d %0d",
                                 want.valid_res, want.vector_index, want.slot_index,
                                 o_item.valid_res, o_item.vector_index, o_item.slot_index);
                end
            end
        end
    end

    // hold the item until the block takes it, then record its address
    task automatic send_item(t_in x, bit typed, t_out want);
        i_valid <= 1'b1;
        i_item <= x;
        do @(posedge i_clk); while (o_stall);
        addr_queue.insert(addr_queue.size(), typed ? want : pack_addr(x));
    endtask

    task automatic drain();
        while (addr_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_setup(logic [15:0] rows, logic [15:0] cols, logic [8:0] dim,
                               logic [8:0] heads, logic [12:0] hwidth, logic [16:0] slots);
        logic [CFG_DATA_W-1:0] vals[6];
        logic [CFG_IDX_W-1:0]  idxs[6];
        vals = '{17'(rows), 17'(cols), 17'(dim), 17'(heads), 17'(hwidth), slots};
        idxs = '{CFG_ROW_COUNT, CFG_COLUMN_COUNT, CFG_BLOCK_DIM,
                 CFG_HEAD_COUNT, CFG_HEAD_WIDTH, CFG_SLOT_COUNT};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        m_rows = rows;
        m_cols = cols;
        m_dim = dim;
        m_heads = heads;
        m_hwidth = hwidth;
        m_slots = slots;
    endtask

    function automatic t_in rand_item();
        t_in x;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            x = 48'({$urandom, $urandom});
        end else begin
            x.row_index = 16'($urandom_range(0, m_rows));
            x.column_index = 16'($urandom_range(0, m_cols));
            x.replica = 16'($urandom_range(0, 65535) >> $urandom_range(4, 16));
        end
        return x;
    endfunction

    task automatic pick_setup(int ph);
        case (ph)
            0: ;
            1: write_setup(16'd65535, 16'd65535, 9'd256, 9'd256, 13'd4096, 17'd65536);
            2: write_setup(16'd0, 16'd0, 9'd0, 9'd0, 13'd0, 17'd0);
            3: write_setup(16'd40, 16'd200, 9'd3, 9'd5, 13'd7, 17'd65537);
            4: write_setup(16'd40, 16'd200, 9'd9, 9'd3, 13'd7, 17'd64);
            5: write_setup(16'd30, 16'd300, 9'd4, 9'd6, 13'd9, 17'd16);
            6: write_setup(16'd30, 16'd300, 9'd2, 9'd7, 13'd5, 17'd12);
            7: write_setup(16'd65535, 16'd65535, 9'd1, 9'd1, 13'd1, 17'd1);
            default: write_setup(16'($urandom_range(1, 300)), 16'($urandom_range(1, 2000)),
                                 9'($urandom_range(1, 8)), 9'($urandom_range(1, 9)),
                                 13'($urandom_range(1, 40)),
                                 17'($urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 16))
                                                          : $urandom_range(1, 4096)));
        endcase
    endtask

    initial begin
        t_in  x;
        int   burst;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ROW_COUNT;
        i_cfg_data = '0;
        m_rows = 16'd1;
        m_cols = 16'd1;
        m_dim = 9'd1;
        m_heads = 9'd1;
        m_hwidth = 13'd1;
        m_slots = 17'd65536;

        // after reset every element (0, 0, r) lands in vector 0, slot r
        dir_tab[0]  = '{'{16'd0, 16'd0, 16'd0},         1, '{1'b1, 20'd0, 16'd0}};
        dir_tab[1]  = '{'{16'd0, 16'd0, 16'd65535},     1, '{1'b1, 20'd0, 16'd65535}};
        dir_tab[2]  = '{'{16'd0, 16'd0, 16'd1234},      1, '{1'b1, 20'd0, 16'd1234}};
        dir_tab[3]  = '{'{16'd1, 16'd0, 16'd0},         1, '{1'b0, 20'd0, 16'd0}};
        dir_tab[4]  = '{'{16'd0, 16'd1, 16'd0},         1, '{1'b0, 20'd0, 16'd0}};
        dir_tab[5]  = '{'{16'd65535, 16'd0, 16'd0},     1, '{1'b0, 20'd0, 16'd0}};
        dir_tab[6]  = '{'{16'd0, 16'd65535, 16'd0},     1, '{1'b0, 20'd0, 16'd0}};
        dir_tab[7]  = '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{1'b0, 20'd0, 16'd0}};
        dir_tab[8]  = '{'{16'h5555, 16'hAAAA, 16'h5555}, 0, '0};
        dir_tab[9]  = '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 0, '0};
        dir_tab[10] = '{'{16'd0, 16'd0, 16'h8000},      0, '0};
        dir_tab[11] = '{'{16'd0, 16'd0, 16'd1},         0, '0};
        dir_tab[12] = '{'{16'd0, 16'd0, 16'h00FF},      0, '0};
        dir_tab[13] = '{'{16'd0, 16'd0, 16'hFF00},      0, '0};
        dir_tab[14] = '{'{16'd1, 16'd1, 16'd1},         0, '0};
        dir_tab[15] = '{'{16'd0, 16'd0, 16'd65534},     0, '0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 16; k++) send_item(dir_tab[k].item, dir_tab[k].typed,
                                              dir_tab[k].want);
        i_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            pick_setup(ph);
            for (int n = 0; n < PHASE_ITEMS; ) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst && n < PHASE_ITEMS; b++, n++) begin
                    x = rand_item();
                    send_item(x, 1'b0, '0);
                end
                if (ph % 3 != 2 && $urandom_range(0, 1)) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            i_valid <= 1'b0;
            // hold off until every address of this setting is back
            drain();
        end

        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pkr_pkg.sv
rtl/core/pkr_div_pipe.sv
rtl/core/pkr_setup.sv
rtl/core/multihead_block_slot_packer_top.sv
verif/tb_multihead_block_slot_packer_top.sv
